>>> sv/ir_pulse_distance_transmitter_defines.svh
// Assertion helpers used by the transmitter core.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_DEFINES_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IRPDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IRPDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/irpdt_pkg.sv
package irpdt_pkg;

    localparam int CODE_BITS  = 49;
    localparam int TIME_WIDTH = 16;
    localparam int BIT_IDX_W  = 6;
    localparam int FRAME_W    = 4;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    // Register indexes, paddr[5:3].
    localparam logic [REG_IDX_W-1:0] REG_CODE_ON    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CODE_OFF   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEADER     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BIT_MARK   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ONE_SPACE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_SPACE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_GAP  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT     = 3'd7;

    localparam logic [CODE_BITS-1:0]  DEF_CODE_ON    = 49'd265042565575245;
    localparam logic [CODE_BITS-1:0]  DEF_CODE_OFF   = 49'd272709516702285;
    localparam logic [TIME_WIDTH-1:0] DEF_HEADER     = 16'd4500;
    localparam logic [TIME_WIDTH-1:0] DEF_BIT_MARK   = 16'd560;
    localparam logic [TIME_WIDTH-1:0] DEF_ONE_SPACE  = 16'd1690;
    localparam logic [TIME_WIDTH-1:0] DEF_ZERO_SPACE = 16'd560;
    localparam logic [TIME_WIDTH-1:0] DEF_FRAME_GAP  = 16'd4200;
    localparam logic [FRAME_W-1:0]    DEF_REPEAT     = 4'd2;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code_on;
        logic [CODE_BITS-1:0]  code_off;
        logic [TIME_WIDTH-1:0] header_time;
        logic [TIME_WIDTH-1:0] bit_mark_time;
        logic [TIME_WIDTH-1:0] one_space_time;
        logic [TIME_WIDTH-1:0] zero_space_time;
        logic [TIME_WIDTH-1:0] frame_gap_time;
        logic [FRAME_W-1:0]    repeat_count;
    } t_cfg;

    typedef struct packed {
        logic req_type;
        logic code_select;
    } t_item;

    typedef struct packed {
        logic rejected;
        logic send_done;
        logic busy_res;
        logic carrier_enable;
    } t_res;

endpackage

>>> sv/irpdt_regs.sv
module irpdt_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [irpdt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [irpdt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [irpdt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output irpdt_pkg::t_cfg                     o_cfg
);

    irpdt_pkg::t_cfg                      r_cfg;
    logic                                 w_wr;
    logic [irpdt_pkg::REG_IDX_W-1:0]      w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[irpdt_pkg::APB_ADDR_W-1 -: irpdt_pkg::REG_IDX_W];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_on         <= irpdt_pkg::DEF_CODE_ON;
            r_cfg.code_off        <= irpdt_pkg::DEF_CODE_OFF;
            r_cfg.header_time     <= irpdt_pkg::DEF_HEADER;
            r_cfg.bit_mark_time   <= irpdt_pkg::DEF_BIT_MARK;
            r_cfg.one_space_time  <= irpdt_pkg::DEF_ONE_SPACE;
            r_cfg.zero_space_time <= irpdt_pkg::DEF_ZERO_SPACE;
            r_cfg.frame_gap_time  <= irpdt_pkg::DEF_FRAME_GAP;
            r_cfg.repeat_count    <= irpdt_pkg::DEF_REPEAT;
        end else if (w_wr) begin
            case (w_idx)
                irpdt_pkg::REG_CODE_ON: begin
                    r_cfg.code_on <= pwdata[irpdt_pkg::CODE_BITS-1:0];
                end
                irpdt_pkg::REG_CODE_OFF: begin
                    r_cfg.code_off <= pwdata[irpdt_pkg::CODE_BITS-1:0];
                end
                irpdt_pkg::REG_HEADER: begin
                    r_cfg.header_time <= pwdata[irpdt_pkg::TIME_WIDTH-1:0];
                end
                irpdt_pkg::REG_BIT_MARK: begin
                    r_cfg.bit_mark_time <= pwdata[irpdt_pkg::TIME_WIDTH-1:0];
                end
                irpdt_pkg::REG_ONE_SPACE: begin
                    r_cfg.one_space_time <= pwdata[irpdt_pkg::TIME_WIDTH-1:0];
                end
                irpdt_pkg::REG_ZERO_SPACE: begin
                    r_cfg.zero_space_time <= pwdata[irpdt_pkg::TIME_WIDTH-1:0];
                end
                irpdt_pkg::REG_FRAME_GAP: begin
                    r_cfg.frame_gap_time <= pwdata[irpdt_pkg::TIME_WIDTH-1:0];
                end
                irpdt_pkg::REG_REPEAT: begin
                    r_cfg.repeat_count <= pwdata[irpdt_pkg::FRAME_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            irpdt_pkg::REG_CODE_ON: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.code_on);
            end
            irpdt_pkg::REG_CODE_OFF: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.code_off);
            end
            irpdt_pkg::REG_HEADER: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.header_time);
            end
            irpdt_pkg::REG_BIT_MARK: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.bit_mark_time);
            end
            irpdt_pkg::REG_ONE_SPACE: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.one_space_time);
            end
            irpdt_pkg::REG_ZERO_SPACE: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.zero_space_time);
            end
            irpdt_pkg::REG_FRAME_GAP: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.frame_gap_time);
            end
            irpdt_pkg::REG_REPEAT: begin
                prdata = irpdt_pkg::APB_DATA_W'(r_cfg.repeat_count);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

>>> sv/irpdt_core.sv
`include "ir_pulse_distance_transmitter_defines.svh"

module irpdt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  irpdt_pkg::t_item  i_item,
    input  irpdt_pkg::t_cfg   i_cfg,
    output irpdt_pkg::t_res   o_res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HMARK,
        PH_HSPACE,
        PH_BMARK,
        PH_BSPACE,
        PH_GAP
    } t_phase;

    t_phase                                r_phase,      n_phase;
    logic [irpdt_pkg::TIME_WIDTH-1:0]      r_time_left,  n_time_left;
    logic [irpdt_pkg::BIT_IDX_W-1:0]       r_bit_index,  n_bit_index;
    logic [irpdt_pkg::FRAME_W-1:0]         r_frames,     n_frames;
    logic                                  r_chosen,     n_chosen;
    irpdt_pkg::t_res                       r_res,        n_res;

    logic [irpdt_pkg::TIME_WIDTH-1:0]      w_dec;
    logic [irpdt_pkg::CODE_BITS-1:0]       w_code;
    logic                                  w_last_frame;

    function automatic logic [irpdt_pkg::TIME_WIDTH-1:0] at_least_one(
        input logic [irpdt_pkg::TIME_WIDTH-1:0] t
    );
        return (t == '0) ? irpdt_pkg::TIME_WIDTH'(1) : t;
    endfunction

    assign w_dec  = (r_time_left != '0) ? r_time_left - irpdt_pkg::TIME_WIDTH'(1) : '0;
    assign w_code = r_chosen ? i_cfg.code_off : i_cfg.code_on;
    // A repeat count of zero compares as one frame.
    assign w_last_frame = ({1'b0, r_frames} + (irpdt_pkg::FRAME_W + 1)'(1))
                          >= {1'b0, i_cfg.repeat_count};

    always_comb begin
        n_phase     = r_phase;
        n_time_left = r_time_left;
        n_bit_index = r_bit_index;
        n_frames    = r_frames;
        n_chosen    = r_chosen;
        n_res       = '0;

        if (i_item.req_type) begin
            if (r_phase == PH_IDLE) begin
                n_chosen    = i_item.code_select;
                n_frames    = '0;
                n_phase     = PH_HMARK;
                n_time_left = at_least_one(i_cfg.header_time);
                n_bit_index = '0;
            end else begin
                n_res.rejected = 1'b1;
            end
        end else if (r_phase != PH_IDLE) begin
            n_time_left = w_dec;
            if (w_dec == '0) begin
                case (r_phase)
                    PH_HMARK: begin
                        n_phase     = PH_HSPACE;
                        n_time_left = at_least_one(i_cfg.header_time);
                    end
                    PH_HSPACE: begin
                        n_phase     = PH_BMARK;
                        n_bit_index = '0;
                        n_time_left = at_least_one(i_cfg.bit_mark_time);
                    end
                    PH_BMARK: begin
                        n_phase     = PH_BSPACE;
                        n_time_left = w_code[r_bit_index]
                                      ? at_least_one(i_cfg.one_space_time)
                                      : at_least_one(i_cfg.zero_space_time);
                    end
                    default: begin
                        // Bit space and gap: either the next bit, the gap, or frame end.
                        if (r_phase == PH_BSPACE &&
                            r_bit_index != irpdt_pkg::BIT_IDX_W'(irpdt_pkg::CODE_BITS - 1)) begin
                            n_bit_index = r_bit_index + irpdt_pkg::BIT_IDX_W'(1);
                            n_phase     = PH_BMARK;
                            n_time_left = at_least_one(i_cfg.bit_mark_time);
                        end else if (r_phase == PH_BSPACE && i_cfg.frame_gap_time != '0) begin
                            n_phase     = PH_GAP;
                            n_time_left = i_cfg.frame_gap_time;
                        end else if (w_last_frame) begin
                            n_phase         = PH_IDLE;
                            n_time_left     = '0;
                            n_bit_index     = '0;
                            n_frames        = '0;
                            n_res.send_done = 1'b1;
                        end else begin
                            n_frames    = r_frames + irpdt_pkg::FRAME_W'(1);
                            n_phase     = PH_HMARK;
                            n_time_left = at_least_one(i_cfg.header_time);
                            n_bit_index = '0;
                        end
                    end
                endcase
            end
        end

        n_res.carrier_enable = (n_phase == PH_HMARK) || (n_phase == PH_BMARK);
        n_res.busy_res       = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time_left <= '0;
            r_bit_index <= '0;
            r_frames    <= '0;
            r_chosen    <= 1'b0;
            r_res       <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_time_left <= n_time_left;
            r_bit_index <= n_bit_index;
            r_frames    <= n_frames;
            r_chosen    <= n_chosen;
            r_res       <= n_res;
        end
    end

    assign o_res = r_res;

    `IRPDT_ASSERT_NOW(a_bit_index_range, i_clk, i_rst_n, 1'b1,
        r_bit_index < irpdt_pkg::BIT_IDX_W'(irpdt_pkg::CODE_BITS), "bit index out of range")
    `IRPDT_ASSERT_NOW(a_idle_clean, i_clk, i_rst_n, r_phase == PH_IDLE,
        r_time_left == '0 && r_frames == '0, "idle with counters left over")
    `IRPDT_ASSERT_NEXT(a_reject_holds, i_clk, i_rst_n,
        i_step && i_item.req_type && r_phase != PH_IDLE,
        r_res.rejected && r_phase == $past(r_phase), "busy start changed the sequence")
    `IRPDT_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_res.send_done,
        r_phase == PH_IDLE && !r_res.busy_res, "done reported while still busy")

endmodule

>>> sv/ir_pulse_distance_transmitter.sv
// A transaction accepted on the input passes through the input register and then the
// sequencer's result register before it appears; a stalled result stage holds it back.
// Throughput: one item per cycle unless m_axis_tready stalls the result stage.
// Reset (synchronous, active low): sequencer idle, both stages empty, registers at defaults.
// No clearing pass is needed after reset; the block accepts items once reset is released.
module ir_pulse_distance_transmitter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [0] code_select
    input  logic                                s_axis_tuser,   // [0] req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] carrier_enable, [1] busy_res, [2] send_done, [3] rejected
    output logic [7:0]                          m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [irpdt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [irpdt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [irpdt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    irpdt_pkg::t_cfg   w_cfg;
    irpdt_pkg::t_res   w_res;
    irpdt_pkg::t_item  r_item;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_adv;
    logic              w_step;

    // The result stage moves whenever it is empty or being drained.
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= w_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.req_type    <= s_axis_tuser;
            r_item.code_select <= s_axis_tdata[0];
        end
    end

    irpdt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    irpdt_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, w_res.rejected, w_res.send_done,
                            w_res.busy_res, w_res.carrier_enable};

endmodule

>>> bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam int RANDOM_ITEMS   = 150;
    localparam int IDLE_PCT       = 34;
    localparam int HOLD_OFF_TICKS = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 50;

    typedef enum logic [2:0] {
        SEG_IDLE,
        SEG_HDR_MARK,
        SEG_HDR_SPACE,
        SEG_BIT_MARK,
        SEG_BIT_SPACE,
        SEG_GAP
    } t_tx_seg;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [0] code_select
    logic                             s_axis_tuser;   // [0] req_type
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // [0] carrier_enable, [1] busy_res, [2] send_done, [3] rejected
    logic [7:0]                       m_axis_tdata;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [irpdt_pkg::APB_ADDR_W-1:0] paddr;
    logic [irpdt_pkg::APB_DATA_W-1:0] pwdata;
    logic [irpdt_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    // Shadow of the transmitter: registers and sequencer state.
    irpdt_pkg::t_cfg                  cfg_shadow;
    t_tx_seg                          tx_seg;
    logic [irpdt_pkg::TIME_WIDTH-1:0] seg_ticks_left;
    int unsigned                      bit_pos;
    int unsigned                      frames_done;
    logic                             send_code_off;

    irpdt_pkg::t_res expected_q[$];
    int unsigned     items_sent;
    int unsigned     mismatches;
    int unsigned     stall_cycles;
    int              hold_off_left;
    bit              sender_gaps;
    bit              receiver_gaps;

    ir_pulse_distance_transmitter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        // Keep the log short when a systematic fault repeats on every transaction.
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
        end
        mismatches++;
    endtask

    function automatic logic [irpdt_pkg::TIME_WIDTH-1:0] at_least_one_tick(
        input logic [irpdt_pkg::TIME_WIDTH-1:0] len);
        return (len == '0) ? irpdt_pkg::TIME_WIDTH'(1) : len;
    endfunction

    function automatic void clear_sequencer();
        tx_seg         = SEG_IDLE;
        seg_ticks_left = '0;
        bit_pos        = 0;
        frames_done    = 0;
        send_code_off  = 1'b0;
    endfunction

    function automatic void reset_shadow();
        cfg_shadow.code_on         = irpdt_pkg::DEF_CODE_ON;
        cfg_shadow.code_off        = irpdt_pkg::DEF_CODE_OFF;
        cfg_shadow.header_time     = irpdt_pkg::DEF_HEADER;
        cfg_shadow.bit_mark_time   = irpdt_pkg::DEF_BIT_MARK;
        cfg_shadow.one_space_time  = irpdt_pkg::DEF_ONE_SPACE;
        cfg_shadow.zero_space_time = irpdt_pkg::DEF_ZERO_SPACE;
        cfg_shadow.frame_gap_time  = irpdt_pkg::DEF_FRAME_GAP;
        cfg_shadow.repeat_count    = irpdt_pkg::DEF_REPEAT;
        clear_sequencer();
    endfunction

    function automatic void start_frame();
        tx_seg         = SEG_HDR_MARK;
        seg_ticks_left = at_least_one_tick(cfg_shadow.header_time);
        bit_pos        = 0;
    endfunction

    // Returns 1 when the frame just closed was the last one of the transmission.
    function automatic bit finish_frame();
        if (frames_done + 1 >= cfg_shadow.repeat_count) begin
            clear_sequencer();
            return 1'b1;
        end
        frames_done = (frames_done + 1) & 15;
        start_frame();
        return 1'b0;
    endfunction

    function automatic bit next_segment();
        logic [irpdt_pkg::CODE_BITS-1:0] code;
        case (tx_seg)
            SEG_HDR_MARK: begin
                tx_seg         = SEG_HDR_SPACE;
                seg_ticks_left = at_least_one_tick(cfg_shadow.header_time);
            end
            SEG_HDR_SPACE: begin
                tx_seg         = SEG_BIT_MARK;
                bit_pos        = 0;
                seg_ticks_left = at_least_one_tick(cfg_shadow.bit_mark_time);
            end
            SEG_BIT_MARK: begin
                // The code bit is taken from the live register as the space begins.
                code   = send_code_off ? cfg_shadow.code_off : cfg_shadow.code_on;
                tx_seg = SEG_BIT_SPACE;
                seg_ticks_left = code[bit_pos]
                    ? at_least_one_tick(cfg_shadow.one_space_time)
                    : at_least_one_tick(cfg_shadow.zero_space_time);
            end
            SEG_BIT_SPACE: begin
                if (bit_pos + 1 < irpdt_pkg::CODE_BITS) begin
                    bit_pos++;
                    tx_seg         = SEG_BIT_MARK;
                    seg_ticks_left = at_least_one_tick(cfg_shadow.bit_mark_time);
                end else if (cfg_shadow.frame_gap_time == 0) begin
                    return finish_frame();
                end else begin
                    tx_seg         = SEG_GAP;
                    seg_ticks_left = cfg_shadow.frame_gap_time;
                end
            end
            default: begin
                return finish_frame();
            end
        endcase
        return 1'b0;
    endfunction

    function automatic irpdt_pkg::t_res transmit_step(input irpdt_pkg::t_item it);
        irpdt_pkg::t_res res;
        res = '0;
        if (it.req_type == REQ_START) begin
            if (tx_seg == SEG_IDLE) begin
                send_code_off = it.code_select;
                frames_done   = 0;
                start_frame();
            end else begin
                res.rejected = 1'b1;
            end
        end else if (tx_seg != SEG_IDLE) begin
            if (seg_ticks_left > 0) begin
                seg_ticks_left--;
            end
            if (seg_ticks_left == 0 && next_segment()) begin
                res.send_done = 1'b1;
            end
        end
        res.carrier_enable = (tx_seg == SEG_HDR_MARK) || (tx_seg == SEG_BIT_MARK);
        res.busy_res       = (tx_seg != SEG_IDLE);
        return res;
    endfunction

    function automatic logic [irpdt_pkg::APB_DATA_W-1:0] register_value(
        input logic [irpdt_pkg::REG_IDX_W-1:0] idx);
        case (idx)
            irpdt_pkg::REG_CODE_ON:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.code_on);
            irpdt_pkg::REG_CODE_OFF:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.code_off);
            irpdt_pkg::REG_HEADER:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.header_time);
            irpdt_pkg::REG_BIT_MARK:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.bit_mark_time);
            irpdt_pkg::REG_ONE_SPACE:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.one_space_time);
            irpdt_pkg::REG_ZERO_SPACE:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.zero_space_time);
            irpdt_pkg::REG_FRAME_GAP:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.frame_gap_time);
            default:
                return irpdt_pkg::APB_DATA_W'(cfg_shadow.repeat_count);
        endcase
    endfunction

    task automatic apb_access(input bit is_write,
                              input logic [irpdt_pkg::REG_IDX_W-1:0] idx,
                              input logic [irpdt_pkg::APB_DATA_W-1:0] wdata,
                              output logic [irpdt_pkg::APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [irpdt_pkg::REG_IDX_W-1:0] idx);
        logic [irpdt_pkg::APB_DATA_W-1:0] rdata;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== register_value(idx)) begin
            report_mismatch($sformatf("register %0d readback", idx), rdata,
                            register_value(idx));
        end
    endtask

    // Bits above the register width are dropped by the block.
    task automatic write_reg(input logic [irpdt_pkg::REG_IDX_W-1:0] idx,
                             input logic [irpdt_pkg::APB_DATA_W-1:0] value);
        logic [irpdt_pkg::APB_DATA_W-1:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            irpdt_pkg::REG_CODE_ON:
                cfg_shadow.code_on = value[irpdt_pkg::CODE_BITS-1:0];
            irpdt_pkg::REG_CODE_OFF:
                cfg_shadow.code_off = value[irpdt_pkg::CODE_BITS-1:0];
            irpdt_pkg::REG_HEADER:
                cfg_shadow.header_time = value[irpdt_pkg::TIME_WIDTH-1:0];
            irpdt_pkg::REG_BIT_MARK:
                cfg_shadow.bit_mark_time = value[irpdt_pkg::TIME_WIDTH-1:0];
            irpdt_pkg::REG_ONE_SPACE:
                cfg_shadow.one_space_time = value[irpdt_pkg::TIME_WIDTH-1:0];
            irpdt_pkg::REG_ZERO_SPACE:
                cfg_shadow.zero_space_time = value[irpdt_pkg::TIME_WIDTH-1:0];
            irpdt_pkg::REG_FRAME_GAP:
                cfg_shadow.frame_gap_time = value[irpdt_pkg::TIME_WIDTH-1:0];
            default:
                cfg_shadow.repeat_count = value[irpdt_pkg::FRAME_W-1:0];
        endcase
        check_reg(idx);
    endtask

    task automatic write_timing(input logic [irpdt_pkg::APB_DATA_W-1:0] header,
                                input logic [irpdt_pkg::APB_DATA_W-1:0] mark,
                                input logic [irpdt_pkg::APB_DATA_W-1:0] one_space,
                                input logic [irpdt_pkg::APB_DATA_W-1:0] zero_space,
                                input logic [irpdt_pkg::APB_DATA_W-1:0] gap,
                                input logic [irpdt_pkg::APB_DATA_W-1:0] repeats);
        write_reg(irpdt_pkg::REG_HEADER, header);
        write_reg(irpdt_pkg::REG_BIT_MARK, mark);
        write_reg(irpdt_pkg::REG_ONE_SPACE, one_space);
        write_reg(irpdt_pkg::REG_ZERO_SPACE, zero_space);
        write_reg(irpdt_pkg::REG_FRAME_GAP, gap);
        write_reg(irpdt_pkg::REG_REPEAT, repeats);
    endtask

    task automatic send_item(input logic req, input logic sel);
        irpdt_pkg::t_item it;
        it.req_type    = req;
        it.code_select = sel;
        @(negedge i_clk);
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {7'd0, sel};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(transmit_step(it));
        items_sent++;
    endtask

    // Stops offering transactions and waits until every expected result is in.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Ticks the transmission to its end, with start requests mixed in at reject_pct percent.
    task automatic run_to_done(input int reject_pct);
        while (tx_seg != SEG_IDLE) begin
            if ($urandom_range(99) < reject_pct) begin
                send_item(REQ_START, 1'($urandom_range(1)));
            end else begin
                send_item(REQ_TICK, 1'($urandom_range(1)));
            end
        end
    endtask

    function automatic logic [irpdt_pkg::TIME_WIDTH-1:0] short_len();
        return ($urandom_range(3) == 0) ? irpdt_pkg::TIME_WIDTH'($urandom_range(4, 2))
                                        : irpdt_pkg::TIME_WIDTH'($urandom_range(1));
    endfunction

    // Puts random junk above the register field.
    function automatic logic [irpdt_pkg::APB_DATA_W-1:0] with_junk(
        input logic [irpdt_pkg::TIME_WIDTH-1:0] v);
        logic [irpdt_pkg::APB_DATA_W-1:0] w;
        w = {$urandom(), $urandom()};
        w[irpdt_pkg::TIME_WIDTH-1:0] = v;
        return w;
    endfunction

    task automatic test_register_defaults();
        for (int i = irpdt_pkg::REG_CODE_ON; i <= irpdt_pkg::REG_REPEAT; i++) begin
            check_reg(irpdt_pkg::REG_IDX_W'(i));
        end
    endtask

    task automatic test_idle_ticks();
        send_item(REQ_TICK, 1'b0);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_TICK, 1'b0);
        drain_results();
    endtask

    // Zero lengths count as one tick, a zero gap is skipped, zero repeats send once.
    task automatic test_shortest_segments();
        write_reg(irpdt_pkg::REG_CODE_ON, '1);
        write_timing('0, '0, '0, '0, '0, '0);
        send_item(REQ_START, 1'b0);
        send_item(REQ_START, 1'b1);
        send_item(REQ_START, 1'b0);
        run_to_done(10);
        send_item(REQ_TICK, 1'b1);
        drain_results();
    endtask

    task automatic test_code_select();
        write_reg(irpdt_pkg::REG_CODE_ON, '0);
        write_reg(irpdt_pkg::REG_CODE_OFF, 64'h5555_5555_5555_5555);
        write_timing(2, 1, 3, 1, 3, 1);
        send_item(REQ_START, 1'b1);
        run_to_done(5);
        send_item(REQ_START, 1'b0);
        run_to_done(0);
        drain_results();
    endtask

    // Code bits and the repeat count are read live while a transmission runs.
    task automatic test_live_register_update();
        write_reg(irpdt_pkg::REG_CODE_ON, {$urandom(), $urandom()});
        write_timing(1, 1, 2, 1, 2, 64'hF);
        send_item(REQ_START, 1'b0);
        repeat (60) send_item(REQ_TICK, 1'($urandom_range(1)));
        drain_results();
        write_reg(irpdt_pkg::REG_CODE_ON, ~register_value(irpdt_pkg::REG_CODE_ON));
        write_reg(irpdt_pkg::REG_ONE_SPACE, 1);
        write_reg(irpdt_pkg::REG_REPEAT, 2);
        run_to_done(2);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_timing(1, 1, 2, 1, 1, 1);
        send_item(REQ_START, 1'b1);
        sender_gaps   = 1'b0;
        hold_off_left = HOLD_OFF_TICKS;
        repeat (30) send_item(REQ_TICK, 1'($urandom_range(1)));
        drain_results();
        sender_gaps = 1'b1;
        run_to_done(5);
        drain_results();
    endtask

    task automatic test_random_transmissions();
        int unsigned busy_items;
        int unsigned n_tx;
        int unsigned mark;
        busy_items = 0;
        n_tx       = 0;
        while (busy_items < RANDOM_ITEMS) begin
            // The first transmission runs with both sides streaming flat out.
            sender_gaps   = (n_tx != 0);
            receiver_gaps = (n_tx != 0);
            write_reg(irpdt_pkg::REG_CODE_ON, {$urandom(), $urandom()});
            write_reg(irpdt_pkg::REG_CODE_OFF, {$urandom(), $urandom()});
            write_timing(with_junk(short_len()), with_junk(short_len()),
                         with_junk(short_len()), with_junk(short_len()),
                         with_junk(short_len()),
                         {$urandom(), 28'($urandom()), 4'($urandom_range(1))});
            repeat ($urandom_range(3)) send_item(REQ_TICK, 1'($urandom_range(1)));
            mark = items_sent;
            send_item(REQ_START, 1'($urandom_range(1)));
            run_to_done(3);
            busy_items += items_sent - mark;
            n_tx++;
            drain_results();
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // Longest lengths and repeat count; the transmission is left running at the end.
    task automatic test_longest_segments();
        write_reg(irpdt_pkg::REG_CODE_OFF, '0);
        write_timing('1, '1, '1, '1, '1, '1);
        send_item(REQ_START, 1'($urandom_range(1)));
        repeat (20) send_item(REQ_TICK, 1'($urandom_range(1)));
        send_item(REQ_START, 1'($urandom_range(1)));
        repeat (20) send_item(REQ_TICK, 1'($urandom_range(1)));
        drain_results();
    endtask

    // Receiver: random stalls, plus a long hold-off on request from the test.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_off_left--;
            end else begin
                m_axis_tready <= !(receiver_gaps && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        irpdt_pkg::t_res got;
        irpdt_pkg::t_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = irpdt_pkg::t_res'(m_axis_tdata[3:0]);
            if (expected_q.size() == 0) begin
                report_mismatch("result with no transaction pending", got, '0);
            end else begin
                want = expected_q.pop_front();
                if (got.carrier_enable !== want.carrier_enable)
                    report_mismatch("carrier_enable", got.carrier_enable, want.carrier_enable);
                if (got.busy_res !== want.busy_res)
                    report_mismatch("busy_res", got.busy_res, want.busy_res);
                if (got.send_done !== want.send_done)
                    report_mismatch("send_done", got.send_done, want.send_done);
                if (got.rejected !== want.rejected)
                    report_mismatch("rejected", got.rejected, want.rejected);
            end
        end
    end

    // Ends the run when neither side has moved a transaction for too long.
    initial begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        items_sent    = 0;
        mismatches    = 0;
        hold_off_left = 0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        reset_shadow();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_register_defaults();
        test_idle_ticks();
        test_shortest_segments();
        test_code_select();
        test_live_register_update();
        test_backpressure();
        test_random_transmissions();
        test_longest_segments();

        repeat (8) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            report_mismatch("results never delivered", expected_q.size(), '0);
        end
        if (mismatches == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
